// ===== design/segment_rect_intersect_defines.svh =====
// ----------------------------------------------------------------------------
// segment_rect_intersect_defines
// assertion macros for the segment/rectangle intersection block
// ----------------------------------------------------------------------------
`ifndef SEGMENT_RECT_INTERSECT_DEFINES_SVH
`define SEGMENT_RECT_INTERSECT_DEFINES_SVH
`ifndef ASSERT_OFF
`define SRI_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SRI_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SRI_ASSERT(label, clk, rst_n, prop, msg)
`define SRI_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ===== design/sri_pkg.sv =====
// ----------------------------------------------------------------------------
// sri_pkg
// shared widths and types of the segment/rectangle intersection block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package sri_pkg;
	localparam int CW = 24;      // coordinate width
	localparam int SW = 23;      // size width
	localparam int NW = 27;      // clip parameter numerator/denominator width
	localparam int PW = 2 * NW;  // cross product width
	localparam int QD = 2;       // queue depth

	typedef struct packed {
		logic signed [NW-1:0] n;
		logic signed [NW-1:0] d;
	} frac_t;

	typedef struct packed {
		frac_t lo_x;
		frac_t lo_y;
		frac_t hi_x;
		frac_t hi_y;
		logic  reject;
	} clip_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic full;
		logic empty;
	} q_stat_t;
endpackage

// ===== design/sri_front.sv =====
// ----------------------------------------------------------------------------
// sri_front
// accepts a request and reduces each axis to entry and exit parameters
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sri_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           take,
	input  logic signed [sri_pkg::CW-1:0]  start_x,
	input  logic signed [sri_pkg::CW-1:0]  start_y,
	input  logic signed [sri_pkg::CW-1:0]  end_x,
	input  logic signed [sri_pkg::CW-1:0]  end_y,
	input  logic signed [sri_pkg::CW-1:0]  rect_left,
	input  logic signed [sri_pkg::CW-1:0]  rect_top,
	input  logic        [sri_pkg::SW-1:0]  rect_width,
	input  logic        [sri_pkg::SW-1:0]  rect_height,
	output logic                           valid_s1,
	output sri_pkg::clip_t                 clip_s1
);
	import sri_pkg::*;

	logic  rej_x, rej_y;
	frac_t lo_x, hi_x, lo_y, hi_y;

	// one axis: direction, near edge, far edge
	function automatic logic [4*NW:0] axis(input logic signed [CW-1:0] s,
		input logic signed [CW-1:0] e, input logic signed [CW-1:0] mn,
		input logic [SW-1:0] sz);
		logic signed [NW-1:0] dv, d0, d1, ln, ld, hn, hd;
		logic                 rej;
		begin
			dv  = NW'(e) - NW'(s);
			d0  = NW'(s) - NW'(mn);
			d1  = NW'(mn) + $signed({{(NW-SW){1'b0}}, sz}) - NW'(s);
			rej = 1'b0;
			ln  = '0;
			ld  = NW'(1);
			hn  = NW'(1);
			hd  = NW'(1);
			if (dv == '0) begin
				rej = (d0 < 0) || (d1 < 0);
			end else if (dv > 0) begin
				ln = -d0; ld = dv; hn = d1; hd = dv;
			end else begin
				ln = -d1; ld = -dv; hn = d0; hd = -dv;
			end
			// clamp entry at 0 and exit at 1
			if (!(ln > 0)) begin
				ln = '0; ld = NW'(1);
			end
			if (!(hn < hd)) begin
				hn = NW'(1); hd = NW'(1);
			end
			axis = {ln, ld, hn, hd, rej};
		end
	endfunction

	always_comb begin
		{lo_x.n, lo_x.d, hi_x.n, hi_x.d, rej_x} =
			axis(start_x, end_x, rect_left, rect_width);
		{lo_y.n, lo_y.d, hi_y.n, hi_y.d, rej_y} =
			axis(start_y, end_y, rect_top, rect_height);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			clip_s1 <= '{lo_x: lo_x, lo_y: lo_y, hi_x: hi_x, hi_y: hi_y,
				reject: rej_x | rej_y};
		end
	end
endmodule

// ===== design/sri_queue.sv =====
// ----------------------------------------------------------------------------
// sri_queue
// short queue between front and back parts
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sri_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sri_pkg::clip_t wdata,
	input  logic           pop,
	output sri_pkg::clip_t rdata,
	output logic           full,
	output logic           empty
);
	import sri_pkg::*;

	localparam int AW = $clog2(QD);

	clip_t         mem_q [QD];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;

	assign full  = (cnt_q == (AW+1)'(QD));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= (wr_q == AW'(QD-1)) ? '0 : wr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_q <= (rd_q == AW'(QD-1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
		end
	end
endmodule

// ===== design/sri_back.sv =====
// ----------------------------------------------------------------------------
// sri_back
// merges axis parameters by cross products and decides the hit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sri_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  sri_pkg::clip_t clip,
	output logic           done,
	output logic           intersects
);
	import sri_pkg::*;

	logic                 v_s2, v_s3, v_s4;
	logic                 rej_s2, rej_s3, rej_s4;
	frac_t                lox_s2, loy_s2, hix_s2, hiy_s2;
	logic signed [PW-1:0] la_s2, lb_s2, ha_s2, hb_s2;
	frac_t                lo_s3, hi_s3;
	logic signed [PW-1:0] xa_s4, xb_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s2 <= in_valid;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			done <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		// cross products of the two entry and the two exit candidates
		lox_s2 <= clip.lo_x;
		loy_s2 <= clip.lo_y;
		hix_s2 <= clip.hi_x;
		hiy_s2 <= clip.hi_y;
		rej_s2 <= clip.reject;
		la_s2  <= PW'(clip.lo_x.n) * PW'(clip.lo_y.d);
		lb_s2  <= PW'(clip.lo_y.n) * PW'(clip.lo_x.d);
		ha_s2  <= PW'(clip.hi_x.n) * PW'(clip.hi_y.d);
		hb_s2  <= PW'(clip.hi_y.n) * PW'(clip.hi_x.d);
		// latest entry, earliest exit
		lo_s3  <= (la_s2 > lb_s2) ? lox_s2 : loy_s2;
		hi_s3  <= (ha_s2 < hb_s2) ? hix_s2 : hiy_s2;
		rej_s3 <= rej_s2;
		xa_s4  <= PW'(lo_s3.n) * PW'(hi_s3.d);
		xb_s4  <= PW'(hi_s3.n) * PW'(lo_s3.d);
		rej_s4 <= rej_s3;
		intersects <= !rej_s4 && !(xa_s4 > xb_s4);
	end
endmodule

// ===== design/segment_rect_intersect.sv =====
// ----------------------------------------------------------------------------
// segment_rect_intersect
// liang-barsky test of one segment against one axis-aligned rectangle
// ----------------------------------------------------------------------------
// channel   ports                              handshake
// request   start_x .. rect_height             start && !busy
// result    intersects                         done, one cycle
//
// one request per cycle while busy is low; done is high for the cycle in which intersects holds the result
// the result passes the front register, the queue entry, then four back stages
// (entry/exit cross products, select, final cross product, output register)
// arst_n clears all valid bits and the queue pointers
// the receiver cannot stall, so the queue never holds more than one entry
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "segment_rect_intersect_defines.svh"
module segment_rect_intersect (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic signed [sri_pkg::CW-1:0]  start_x,
	input  logic signed [sri_pkg::CW-1:0]  start_y,
	input  logic signed [sri_pkg::CW-1:0]  end_x,
	input  logic signed [sri_pkg::CW-1:0]  end_y,
	input  logic signed [sri_pkg::CW-1:0]  rect_left,
	input  logic signed [sri_pkg::CW-1:0]  rect_top,
	input  logic        [sri_pkg::SW-1:0]  rect_width,
	input  logic        [sri_pkg::SW-1:0]  rect_height,
	output logic                           done,
	output logic                           intersects
);
	import sri_pkg::*;

	logic    take, fv_s1;
	clip_t   fclip_s1, head;
	q_stat_t qs;

	assign take = start && !busy;

	// front: per-axis entry/exit parameters and parallel reject
	sri_front u_front (
		.clk, .arst_n, .take,
		.start_x, .start_y, .end_x, .end_y,
		.rect_left, .rect_top, .rect_width, .rect_height,
		.valid_s1(fv_s1), .clip_s1(fclip_s1)
	);

	assign qs.push = fv_s1;
	assign qs.pop  = !qs.empty;  // back part never stalls

	sri_queue u_queue (
		.clk, .arst_n,
		.push(qs.push), .wdata(fclip_s1),
		.pop(qs.pop), .rdata(head),
		.full(qs.full), .empty(qs.empty)
	);

	assign busy = qs.full;

	// back: cross-multiplied compares, then the final hit decision
	sri_back u_back (
		.clk, .arst_n,
		.in_valid(qs.pop), .clip(head),
		.done, .intersects
	);

	`SRI_NEVER(a_no_overflow, clk, arst_n, qs.push && qs.full, "queue overflow")
	`SRI_ASSERT(a_latency, clk, arst_n, take |-> ##6 done, "result missing")
	`SRI_NEVER(a_pop_empty, clk, arst_n, qs.pop && qs.empty, "pop on empty queue")
endmodule
